/* rtl/swam_pkg.sv */
// ---------------------------------------------------------------------------
// swam_pkg: shared types and constants for the sliding window anagram matcher
// Item layouts, store sizes and the letter-count store interface structs.
// ---------------------------------------------------------------------------
package swam_pkg;

   // alphabet and field widths
   localparam int NUM_LETTERS = 26;
   localparam int LETTER_W    = 5;
   localparam int MODE_W      = 2;

   // pattern capacity, ring of recent text letters
   localparam int MAX_PATTERN = 1024;
   localparam int RING_AW     = $clog2(MAX_PATTERN);
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
   // per-letter counters wrap; their difference is a signed balance
   localparam int CNT_W       = LEN_W + 1;

   // result queue
   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W   = $clog2(RSP_DEPTH + 1);

   // item modes
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PATTERN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TEXT    = 2'd2;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [CNT_W-1:0]    count_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      letter_type        letter_code;
   } req_type;

   typedef struct packed {
      logic window_match;
      logic found;
      logic pattern_overflow;
   } rsp_type;

   // read addresses: entering letter and leaving letter
   typedef struct packed {
      letter_type addr_c;
      letter_type addr_g;
   } bal_rd_type;

   // one write per bank per cycle
   typedef struct packed {
      logic       inc_en;
      letter_type inc_addr;
      count_type  inc_data;
      logic       dec_en;
      letter_type dec_addr;
      count_type  dec_data;
   } bal_wr_type;

   // resolved counts, valid in the cycle after the read
   typedef struct packed {
      count_type inc_c;
      count_type dec_c;
      count_type inc_g;
      count_type dec_g;
   } bal_data_type;

endpackage

/* rtl/swam_bal_store.sv */
// ---------------------------------------------------------------------------
// swam_bal_store: per-letter count store
// Two 26-entry banks (raised counts, lowered counts), each read at two
// letters with registered data and written at one. Valid bits per bank give
// a clear without a sweep; the write made at the read edge is forwarded.
// ---------------------------------------------------------------------------
module swam_bal_store (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  swam_pkg::bal_rd_type   rd,
   input  swam_pkg::bal_wr_type   wr,
   output swam_pkg::bal_data_type rd_data
);
   import swam_pkg::*;

   count_type                inc_mem_ff [NUM_LETTERS];
   count_type                dec_mem_ff [NUM_LETTERS];
   logic [NUM_LETTERS-1:0]   inc_vld_ff;
   logic [NUM_LETTERS-1:0]   dec_vld_ff;
   count_type                inc_c_ff, dec_c_ff, inc_g_ff, dec_g_ff;
   letter_type               addr_c_ff, addr_g_ff;
   bal_wr_type               byp_ff;

   // memory banks: registered reads, read-first
   always_ff @(posedge clock) begin
      inc_c_ff <= inc_mem_ff[rd.addr_c];
      inc_g_ff <= inc_mem_ff[rd.addr_g];
      dec_c_ff <= dec_mem_ff[rd.addr_c];
      dec_g_ff <= dec_mem_ff[rd.addr_g];
      if (wr.inc_en) begin
         inc_mem_ff[wr.inc_addr] <= wr.inc_data;
      end
      if (wr.dec_en) begin
         dec_mem_ff[wr.dec_addr] <= wr.dec_data;
      end
      addr_c_ff <= rd.addr_c;
      addr_g_ff <= rd.addr_g;
   end

   // valid bits and forwarding register
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         inc_vld_ff    <= '0;
         dec_vld_ff    <= '0;
         byp_ff.inc_en <= 1'b0;
         byp_ff.dec_en <= 1'b0;
      end else begin
         if (wr.inc_en) begin
            inc_vld_ff[wr.inc_addr] <= 1'b1;
         end
         if (wr.dec_en) begin
            dec_vld_ff[wr.dec_addr] <= 1'b1;
         end
         byp_ff.inc_en <= wr.inc_en;
         byp_ff.dec_en <= wr.dec_en;
      end
      byp_ff.inc_addr <= wr.inc_addr;
      byp_ff.inc_data <= wr.inc_data;
      byp_ff.dec_addr <= wr.dec_addr;
      byp_ff.dec_data <= wr.dec_data;
   end

   // resolve: forwarded write, else memory if valid, else zero
   always_comb begin
      if (byp_ff.inc_en && byp_ff.inc_addr == addr_c_ff) begin
         rd_data.inc_c = byp_ff.inc_data;
      end else begin
         rd_data.inc_c = inc_vld_ff[addr_c_ff] ? inc_c_ff : '0;
      end
      if (byp_ff.inc_en && byp_ff.inc_addr == addr_g_ff) begin
         rd_data.inc_g = byp_ff.inc_data;
      end else begin
         rd_data.inc_g = inc_vld_ff[addr_g_ff] ? inc_g_ff : '0;
      end
      if (byp_ff.dec_en && byp_ff.dec_addr == addr_c_ff) begin
         rd_data.dec_c = byp_ff.dec_data;
      end else begin
         rd_data.dec_c = dec_vld_ff[addr_c_ff] ? dec_c_ff : '0;
      end
      if (byp_ff.dec_en && byp_ff.dec_addr == addr_g_ff) begin
         rd_data.dec_g = byp_ff.dec_data;
      end else begin
         rd_data.dec_g = dec_vld_ff[addr_g_ff] ? dec_g_ff : '0;
      end
   end

   // a clear item never writes counts
   a_clear_no_write: assert property (@(posedge clock) disable iff (reset)
      clear |-> !(wr.inc_en || wr.dec_en))
      else $error("count write during clear");

endmodule

/* rtl/swam_rsp_queue.sv */
// ---------------------------------------------------------------------------
// swam_rsp_queue: result queue
// Small FIFO of result items between the pipeline and the rsp channel.
// ---------------------------------------------------------------------------
module swam_rsp_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  swam_pkg::rsp_type             push_data,
   input  logic                          pop,
   output logic                          out_valid,
   output swam_pkg::rsp_type             out_data,
   output logic [swam_pkg::RSP_CNT_W-1:0] count
);
   import swam_pkg::*;

   rsp_type                q_mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;

   function automatic logic [RSP_PTR_W-1:0] ptr_next(input logic [RSP_PTR_W-1:0] p);
      logic [RSP_PTR_W-1:0] n;
      n = (p == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : p + RSP_PTR_W'(1);
      return n;
   endfunction

   // pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + RSP_CNT_W'(1);
         2'b01:   count_in = count_ff - RSP_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = q_mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

/* rtl/sliding_window_anagram_matcher.sv */
// ---------------------------------------------------------------------------
// sliding_window_anagram_matcher: streaming anagram window detector
// Pattern letters raise per-letter balances, text letters lower them and the
// letter leaving the window is raised again; a full window with no surplus
// letter is a match, as is any text letter while the pattern is empty.
//
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/stall   | req_data  (mode, letter_code)
//   rsp     | out       | rsp_valid/stall   | rsp_data  (window_match, found,
//           |           |                   |            pattern_overflow)
//
// One item per cycle sustained while rsp_stall is low; rsp_valid rises after
// ring read, count-store read, then update and queue push of the accepted item.
// The per-letter count store (one read-modify-write per bank per item) sets
// the rate; same-letter hazards between neighbouring items are forwarded.
// req_stall rises once four items are in the pipeline or queued for rsp.
// Reset is synchronous; count-store valid bits clear at once, no sweep.
// ---------------------------------------------------------------------------
module sliding_window_anagram_matcher (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  swam_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output swam_pkg::rsp_type rsp_data
);
   import swam_pkg::*;

   localparam int BACK_W   = LEN_W + 1;
   localparam int FLIGHT_W = RSP_CNT_W + 1;

   // pipeline operation codes
   localparam logic [2:0] OP_NONE    = 3'd0;
   localparam logic [2:0] OP_CLEAR   = 3'd1;
   localparam logic [2:0] OP_PATTERN = 3'd2;
   localparam logic [2:0] OP_TEXT    = 3'd3;
   localparam logic [2:0] OP_EMPTY   = 3'd4;

   // front end
   logic                 req_accept;
   logic                 letter_ok;
   logic [LEN_W-1:0]     pat_len_ff, pat_len_in;
   logic [LEN_W-1:0]     text_seen_ff, text_seen_in;
   logic [RING_AW-1:0]   ring_ptr_ff, ring_ptr_in;
   logic                 ovf_ff, ovf_in;
   logic [BACK_W-1:0]    ring_back;
   logic [RING_AW-1:0]   ring_rd_addr;
   logic                 ring_wr;
   logic [2:0]           fe_op;
   logic                 fe_leave;
   logic                 fe_full;

   // ring memory
   letter_type           ring_mem_ff [MAX_PATTERN];
   letter_type           ring_rd_ff;

   // stage 1
   logic                 s1_valid_ff;
   logic [2:0]           s1_op_ff;
   letter_type           s1_letter_ff;
   logic                 s1_leave_ff, s1_full_ff, s1_ovf_ff;

   // stage 2
   logic                 s2_valid_ff;
   logic [2:0]           s2_op_ff;
   letter_type           s2_letter_ff, s2_gone_ff;
   logic                 s2_leave_ff, s2_full_ff, s2_ovf_ff;

   // update
   bal_rd_type           bal_rd;
   bal_wr_type           bal_wr;
   bal_data_type         bal_rdata;
   logic                 bal_clear;
   logic signed [CNT_W-1:0] bal_g_new, bal_c_raw, bal_c_cur;
   logic [LEN_W-1:0]     surplus_ff, surplus_in, surp_tmp;
   logic                 found_ff, found_in;
   logic                 s2_match;
   rsp_type              push_data;

   // queue and credit
   logic [RSP_CNT_W-1:0] q_count;
   logic [FLIGHT_W-1:0]  in_flight;
   logic                 rsp_pop;

   assign in_flight  = FLIGHT_W'(q_count) + FLIGHT_W'(s1_valid_ff) + FLIGHT_W'(s2_valid_ff);
   assign req_stall  = (in_flight >= FLIGHT_W'(RSP_DEPTH));
   assign req_accept = req_valid && !req_stall;
   assign letter_ok  = (req_data.letter_code < LETTER_W'(NUM_LETTERS));

   // ring slot of the letter leaving the window
   always_comb begin
      if (BACK_W'(ring_ptr_ff) >= BACK_W'(pat_len_ff)) begin
         ring_back = BACK_W'(ring_ptr_ff) - BACK_W'(pat_len_ff);
      end else begin
         ring_back = BACK_W'(ring_ptr_ff) + BACK_W'(MAX_PATTERN) - BACK_W'(pat_len_ff);
      end
      ring_rd_addr = ring_back[RING_AW-1:0];
   end

   // front end: lengths, ring pointer, overflow flag
   always_comb begin
      pat_len_in   = pat_len_ff;
      text_seen_in = text_seen_ff;
      ring_ptr_in  = ring_ptr_ff;
      ovf_in       = ovf_ff;
      ring_wr      = 1'b0;
      fe_op        = OP_NONE;
      fe_leave     = 1'b0;
      if (req_accept) begin
         unique case (req_data.mode)
            MODE_CLEAR: begin
               pat_len_in   = '0;
               text_seen_in = '0;
               ring_ptr_in  = '0;
               ovf_in       = 1'b0;
               fe_op        = OP_CLEAR;
            end
            MODE_PATTERN: begin
               if (letter_ok) begin
                  if (pat_len_ff == LEN_W'(MAX_PATTERN)) begin
                     ovf_in = 1'b1;
                  end else begin
                     pat_len_in = pat_len_ff + LEN_W'(1);
                     fe_op      = OP_PATTERN;
                  end
               end
            end
            MODE_TEXT: begin
               if (letter_ok) begin
                  if (pat_len_ff == '0) begin
                     fe_op = OP_EMPTY;
                  end else begin
                     fe_op   = OP_TEXT;
                     ring_wr = 1'b1;
                     ring_ptr_in = (ring_ptr_ff == RING_AW'(MAX_PATTERN - 1)) ?
                                   '0 : ring_ptr_ff + RING_AW'(1);
                     if (text_seen_ff >= pat_len_ff) begin
                        fe_leave = 1'b1;
                     end else begin
                        text_seen_in = text_seen_ff + LEN_W'(1);
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      fe_full = (text_seen_in == pat_len_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff   <= '0;
         text_seen_ff <= '0;
         ring_ptr_ff  <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         pat_len_ff   <= pat_len_in;
         text_seen_ff <= text_seen_in;
         ring_ptr_ff  <= ring_ptr_in;
         ovf_ff       <= ovf_in;
      end
   end

   // ring of recent text letters, read-first
   always_ff @(posedge clock) begin
      if (ring_wr) begin
         ring_mem_ff[ring_ptr_ff] <= req_data.letter_code;
      end
      if (req_accept) begin
         ring_rd_ff <= ring_mem_ff[ring_rd_addr];
      end
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff     <= fe_op;
         s1_letter_ff <= req_data.letter_code;
         s1_leave_ff  <= fe_leave;
         s1_full_ff   <= fe_full;
         s1_ovf_ff    <= ovf_in;
      end
      s2_op_ff     <= s1_op_ff;
      s2_letter_ff <= s1_letter_ff;
      s2_gone_ff   <= ring_rd_ff;
      s2_leave_ff  <= s1_leave_ff;
      s2_full_ff   <= s1_full_ff;
      s2_ovf_ff    <= s1_ovf_ff;
   end

   // count store reads for stage 1
   assign bal_rd.addr_c = s1_letter_ff;
   assign bal_rd.addr_g = ring_rd_ff;

   swam_bal_store u_bal_store (
      .clock   (clock),
      .reset   (reset),
      .clear   (bal_clear),
      .rd      (bal_rd),
      .wr      (bal_wr),
      .rd_data (bal_rdata)
   );

   // balances seen by the item in stage 2
   always_comb begin
      bal_g_new = bal_rdata.inc_g - bal_rdata.dec_g + count_type'(1);
      bal_c_raw = bal_rdata.inc_c - bal_rdata.dec_c;
      bal_c_cur = (s2_leave_ff && s2_letter_ff == s2_gone_ff) ? bal_g_new : bal_c_raw;
   end

   // stage 2: count writes, surplus, match
   always_comb begin
      bal_wr     = '0;
      bal_clear  = 1'b0;
      surplus_in = surplus_ff;
      surp_tmp   = surplus_ff;
      s2_match   = 1'b0;
      if (s2_valid_ff) begin
         unique case (s2_op_ff)
            OP_CLEAR: begin
               bal_clear  = 1'b1;
               surplus_in = '0;
            end
            OP_PATTERN: begin
               bal_wr.inc_en   = 1'b1;
               bal_wr.inc_addr = s2_letter_ff;
               bal_wr.inc_data = bal_rdata.inc_c + count_type'(1);
               if (bal_c_raw < 0 && surplus_ff != '0) begin
                  surplus_in = surplus_ff - LEN_W'(1);
               end
            end
            OP_TEXT: begin
               // leaving letter first, then the entering one
               if (s2_leave_ff) begin
                  bal_wr.inc_en   = 1'b1;
                  bal_wr.inc_addr = s2_gone_ff;
                  bal_wr.inc_data = bal_rdata.inc_g + count_type'(1);
                  if (bal_g_new <= 0 && surp_tmp != '0) begin
                     surp_tmp = surp_tmp - LEN_W'(1);
                  end
               end
               bal_wr.dec_en   = 1'b1;
               bal_wr.dec_addr = s2_letter_ff;
               bal_wr.dec_data = bal_rdata.dec_c + count_type'(1);
               if (bal_c_cur <= 0) begin
                  surp_tmp = surp_tmp + LEN_W'(1);
               end
               surplus_in = surp_tmp;
               s2_match   = s2_full_ff && (surp_tmp == '0);
            end
            OP_EMPTY: begin
               s2_match = 1'b1;
            end
            default: begin
            end
         endcase
      end
      found_in = bal_clear ? 1'b0 : (found_ff | s2_match);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         surplus_ff <= '0;
         found_ff   <= 1'b0;
      end else begin
         surplus_ff <= surplus_in;
         found_ff   <= found_in;
      end
   end

   // result queue
   assign push_data.window_match     = s2_match;
   assign push_data.found            = found_in;
   assign push_data.pattern_overflow = s2_ovf_ff;
   assign rsp_pop                    = rsp_valid && !rsp_stall;

   swam_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff),
      .push_data (push_data),
      .pop       (rsp_pop),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .count     (q_count)
   );

   // window never longer than the pattern
   a_seen_le_len: assert property (@(posedge clock) disable iff (reset)
      text_seen_ff <= pat_len_ff)
      else $error("text_seen beyond pattern length");

   // ring pointer stays inside the ring
   a_ring_ptr: assert property (@(posedge clock) disable iff (reset)
      ring_ptr_ff <= RING_AW'(MAX_PATTERN - 1))
      else $error("ring pointer out of range");

   // items in flight never exceed the queue room
   a_credit: assert property (@(posedge clock) disable iff (reset)
      in_flight <= FLIGHT_W'(RSP_DEPTH))
      else $error("result queue overcommitted");

   // a match leaves the sticky flag set
   a_match_sticky: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_match) |=> found_ff)
      else $error("found flag not set after match");

endmodule
